// ===== rtl/cls_pkg.sv =====
package cls_pkg;

  localparam int COLUMNS = 20;
  localparam int ROWS    = 4;

  localparam int INIT_STEPS = 12;

  typedef enum logic [2:0] {
    KIND_INIT     = 3'd0,
    KIND_SHUTDOWN = 3'd1,
    KIND_CLEAR    = 3'd2,
    KIND_COMMAND  = 3'd3,
    KIND_DATA     = 3'd4,
    KIND_CURSOR   = 3'd5,
    KIND_CG_SEL   = 3'd6,
    KIND_CG_ROW   = 3'd7
  } kind_e;

  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] CMD_CGRAM_ADDR = 8'h40;
  localparam logic [4:0] CG_ROW_MASK    = 5'h1F;

  localparam logic [3:0] NIB_SYNC = 4'h3;
  localparam logic [3:0] NIB_4BIT = 4'h2;

  localparam logic [15:0] PWR_ON_WAIT_US = 16'd50000;
  localparam logic [12:0] WAIT_NIB_US    = 13'd40;
  localparam logic [12:0] WAIT_CMD_US    = 13'd80;
  localparam logic [12:0] WAIT_SLOW_US   = 13'd2040;
  localparam logic [12:0] WAIT_SYNC_US   = 13'd5040;
  localparam logic [12:0] WAIT_SYNC3_US  = 13'd190;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [15:0] pre_wait;
    logic [12:0] post_wait;
  } nib_t;

  function automatic logic [12:0] cmd_post(input logic [7:0] cmd);
    cmd_post = (cmd == CMD_CLEAR || cmd == CMD_HOME) ? WAIT_SLOW_US : WAIT_CMD_US;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    row_base = b;
  endfunction

  function automatic logic [7:0] cursor_cmd(input logic signed [7:0] col,
                                            input logic signed [7:0] row);
    logic [5:0] c;
    logic [1:0] r;
    if (col < 0) c = '0;
    else if (col >= $signed(8'(COLUMNS))) c = 6'(COLUMNS - 1);
    else c = col[5:0];
    if (row < 0) r = '0;
    else if (row >= $signed(8'(ROWS))) r = 2'(ROWS - 1);
    else r = row[1:0];
    cursor_cmd = CMD_DDRAM_ADDR | (row_base(r) + {2'b00, c});
  endfunction

  // power-on sequence: three sync nibbles, switch to 4-bit, then four commands
  function automatic nib_t init_step(input logic [3:0] idx);
    nib_t n;
    n.pre_wait = '0;
    unique case (idx)
      4'd0: begin
        n.nibble = NIB_SYNC; n.pre_wait = PWR_ON_WAIT_US; n.post_wait = WAIT_SYNC_US;
      end
      4'd1:  begin n.nibble = NIB_SYNC; n.post_wait = WAIT_SYNC_US; end
      4'd2:  begin n.nibble = NIB_SYNC; n.post_wait = WAIT_SYNC3_US; end
      4'd3:  begin n.nibble = NIB_4BIT; n.post_wait = WAIT_SYNC3_US; end
      4'd4:  begin n.nibble = CMD_FUNC_SET[7:4]; n.post_wait = WAIT_NIB_US; end
      4'd5:  begin n.nibble = CMD_FUNC_SET[3:0]; n.post_wait = cmd_post(CMD_FUNC_SET); end
      4'd6:  begin n.nibble = CMD_DISP_ON[7:4]; n.post_wait = WAIT_NIB_US; end
      4'd7:  begin n.nibble = CMD_DISP_ON[3:0]; n.post_wait = cmd_post(CMD_DISP_ON); end
      4'd8:  begin n.nibble = CMD_CLEAR[7:4]; n.post_wait = WAIT_NIB_US; end
      4'd9:  begin n.nibble = CMD_CLEAR[3:0]; n.post_wait = cmd_post(CMD_CLEAR); end
      4'd10: begin n.nibble = CMD_ENTRY_MODE[7:4]; n.post_wait = WAIT_NIB_US; end
      4'd11: begin
        n.nibble = CMD_ENTRY_MODE[3:0]; n.post_wait = cmd_post(CMD_ENTRY_MODE);
      end
      default: begin n.nibble = '0; n.post_wait = '0; end
    endcase
    init_step = n;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Turns character-display requests into 4-bit panel transfers, one nibble per
// result, each with its register-select level and the waits in microseconds to
// honor before and after the enable pulse. A request is decoded into a job
// register as it is accepted; the job then hands one nibble per cycle to the
// output register while it is free or not stalled. Init yields 12 nibbles,
// any other request with output yields 2, and a request without output
// (anything before init, a repeated init) yields none. The next request is
// accepted in the cycle the job's final nibble moves to the output register,
// so a full stream runs at one nibble per cycle while the output keeps stall low.
module char_lcd_nibble_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        value_i,
  input  logic signed [7:0] col_i,
  input  logic signed [7:0] row_sel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              rs_o,
  output logic [3:0]        nibble_o,
  output logic [15:0]       pre_wait_us_o,
  output logic [12:0]       post_wait_us_o,
  output logic              last_o
);
  import cls_pkg::*;

  logic        init_q, init_d;
  logic        job_valid_q;
  logic [3:0]  idx_q;
  logic        job_init_q, job_rs_q;
  logic [7:0]  job_byte_q;
  logic [12:0] job_post_q;

  logic        produce, new_init, new_rs;
  logic [7:0]  new_byte;
  logic [12:0] new_post;

  logic        out_valid_q, rs_q, last_q;
  logic [3:0]  nibble_q;
  logic [15:0] pre_q;
  logic [12:0] post_q;

  nib_t cur_nib;
  logic job_last, out_load, job_done, in_acc;

  always_comb begin
    if (job_init_q) begin
      cur_nib  = init_step(idx_q);
      job_last = (idx_q == 4'(INIT_STEPS - 1));
    end else begin
      cur_nib.nibble    = idx_q[0] ? job_byte_q[3:0] : job_byte_q[7:4];
      cur_nib.pre_wait  = '0;
      cur_nib.post_wait = idx_q[0] ? job_post_q : WAIT_NIB_US;
      job_last          = idx_q[0];
    end
  end

  assign out_load   = job_valid_q && (!out_valid_q || !out_stall_i);
  assign job_done   = out_load && job_last;
  assign in_stall_o = job_valid_q && !job_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // request decode
  always_comb begin
    produce  = init_q;
    init_d   = init_q;
    new_init = 1'b0;
    new_rs   = 1'b0;
    new_byte = CMD_CLEAR;
    new_post = cmd_post(CMD_CLEAR);
    unique case (kind_e'(kind_i))
      KIND_INIT: begin
        produce  = !init_q;
        new_init = 1'b1;
        init_d   = 1'b1;
      end
      KIND_SHUTDOWN: init_d = 1'b0;
      KIND_CLEAR: ;
      KIND_COMMAND: begin
        new_byte = value_i;
        new_post = cmd_post(value_i);
      end
      KIND_DATA: begin
        new_rs   = 1'b1;
        new_byte = value_i;
        new_post = WAIT_NIB_US;
      end
      KIND_CURSOR: begin
        new_byte = cursor_cmd(col_i, row_sel_i);
        new_post = cmd_post(new_byte);
      end
      KIND_CG_SEL: begin
        new_byte = CMD_CGRAM_ADDR | {2'b00, value_i[2:0], 3'b000};
        new_post = cmd_post(new_byte);
      end
      KIND_CG_ROW: begin
        new_rs   = 1'b1;
        new_byte = {3'b000, value_i[4:0] & CG_ROW_MASK};
        new_post = WAIT_NIB_US;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= 1'b0;
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (in_acc) begin
      init_q      <= init_d;
      job_valid_q <= produce;
      idx_q       <= '0;
    end else if (out_load) begin
      idx_q <= idx_q + 4'd1;
      if (job_last) job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      job_init_q <= new_init;
      job_rs_q   <= new_rs;
      job_byte_q <= new_byte;
      job_post_q <= new_post;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rs_q     <= job_rs_q;
      nibble_q <= cur_nib.nibble;
      pre_q    <= cur_nib.pre_wait;
      post_q   <= cur_nib.post_wait;
      last_q   <= job_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rs_o           = rs_q;
  assign nibble_o       = nibble_q;
  assign pre_wait_us_o  = pre_q;
  assign post_wait_us_o = post_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/cls_checker.sv =====
module cls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              rs_o,
  input logic [3:0]        nibble_o,
  input logic [15:0]       pre_wait_us_o,
  input logic [12:0]       post_wait_us_o,
  input logic              last_o
);
  import cls_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nibble_o) && $stable(last_o))
    else $error("stalled result changed");

  // the rest of a request follows without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a request");

  // no new request while a stalled result still has nibbles behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !last_o |-> in_stall_o)
    else $error("request accepted mid-sequence");

  // only the first power-on nibble waits before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pre_wait_us_o != 16'd0 |->
      pre_wait_us_o == PWR_ON_WAIT_US && nibble_o == NIB_SYNC && !rs_o && !last_o
      && post_wait_us_o == WAIT_SYNC_US)
    else $error("bad power-on nibble");

endmodule

bind char_lcd_nibble_sequencer cls_checker u_cls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .rs_o           (rs_o),
  .nibble_o       (nibble_o),
  .pre_wait_us_o  (pre_wait_us_o),
  .post_wait_us_o (post_wait_us_o),
  .last_o         (last_o)
);

// ===== dv/tb_char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer;
  import cls_pkg::*;

  localparam logic [15:0] PWR_PRE    = 16'd50000;
  localparam logic [12:0] NIB_POST   = 13'd40;
  localparam logic [12:0] CMD_POST   = 13'd80;
  localparam logic [12:0] SLOW_POST  = 13'd2040;
  localparam logic [12:0] SYNC_POST  = 13'd5040;
  localparam logic [12:0] SYNC3_POST = 13'd190;
  localparam int          RAND_GOAL  = 90;
  localparam int          STALL_LIMIT = 2000;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] pre_wait;
    logic [12:0] post_wait;
    logic        last;
  } lcd_xfer_t;

  // one row of directed stimulus; when typed is set, the expected transfers
  // come from t_cnt/t_rs/t_byte/t_post instead of the predictor
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [7:0]  col;
    logic [7:0]  row_sel;
    logic        typed;
    logic [1:0]  t_cnt;
    logic        t_rs;
    logic [7:0]  t_byte;
    logic [12:0] t_post;
  } lcd_req_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [2:0]        kind_i      = '0;
  logic [7:0]        value_i     = '0;
  logic signed [7:0] col_i       = '0;
  logic signed [7:0] row_sel_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              rs_o;
  logic [3:0]        nibble_o;
  logic [15:0]       pre_wait_us_o;
  logic [12:0]       post_wait_us_o;
  logic              last_o;

  lcd_xfer_t pending_xfers[$];
  bit        lcd_on     = 1'b0;
  bit        calm       = 1'b0;
  bit        hold_go    = 1'b0;
  bit        hold_done  = 1'b0;
  int        hold_cnt   = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  lcd_req_t  dir_tbl [0:25];

  always #4 clk_i = ~clk_i;

  char_lcd_nibble_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .col_i          (col_i),
    .row_sel_i      (row_sel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rs_o           (rs_o),
    .nibble_o       (nibble_o),
    .pre_wait_us_o  (pre_wait_us_o),
    .post_wait_us_o (post_wait_us_o),
    .last_o         (last_o)
  );

  function automatic void push_nib(input logic rs, input logic [3:0] nib,
                                   input logic [15:0] pre, input logic [12:0] post,
                                   input logic fin);
    lcd_xfer_t x;
    x.rs        = rs;
    x.nibble    = nib;
    x.pre_wait  = pre;
    x.post_wait = post;
    x.last      = fin;
    pending_xfers.push_back(x);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic [12:0] post_low, input logic fin);
    push_nib(rs, b[7:4], 16'd0, NIB_POST, 1'b0);
    push_nib(rs, b[3:0], 16'd0, post_low, fin);
  endfunction

  function automatic void push_cmd(input logic [7:0] cmd, input logic fin);
    push_byte(1'b0, cmd, (cmd == 8'h01 || cmd == 8'h02) ? SLOW_POST : CMD_POST, fin);
  endfunction

  // expected panel transfers for one request; returns how many were queued
  function automatic int predict_xfers(input kind_e k, input logic [7:0] v,
                                       input logic signed [7:0] c,
                                       input logic signed [7:0] r);
    int         n0;
    int         cc;
    int         rr;
    logic [7:0] base;
    n0 = pending_xfers.size();
    if (k == KIND_INIT) begin
      if (!lcd_on) begin
        push_nib(1'b0, 4'h3, PWR_PRE, SYNC_POST, 1'b0);
        push_nib(1'b0, 4'h3, 16'd0, SYNC_POST, 1'b0);
        push_nib(1'b0, 4'h3, 16'd0, SYNC3_POST, 1'b0);
        push_nib(1'b0, 4'h2, 16'd0, SYNC3_POST, 1'b0);
        push_cmd(8'h28, 1'b0);
        push_cmd(8'h0C, 1'b0);
        push_cmd(8'h01, 1'b0);
        push_cmd(8'h06, 1'b1);
        lcd_on = 1'b1;
      end
    end else if (lcd_on) begin
      case (k)
        KIND_SHUTDOWN: begin
          push_cmd(8'h01, 1'b1);
          lcd_on = 1'b0;
        end
        KIND_CLEAR:   push_cmd(8'h01, 1'b1);
        KIND_COMMAND: push_cmd(v, 1'b1);
        KIND_DATA:    push_byte(1'b1, v, NIB_POST, 1'b1);
        KIND_CURSOR: begin
          cc = c;
          rr = r;
          if (cc < 0) cc = 0;
          if (cc >= COLUMNS) cc = COLUMNS - 1;
          if (rr < 0) rr = 0;
          if (rr >= ROWS) rr = ROWS - 1;
          case (rr)
            0:       base = 8'h00;
            1:       base = 8'h40;
            2:       base = 8'h14;
            default: base = 8'h54;
          endcase
          push_cmd(8'h80 | 8'(base + cc), 1'b1);
        end
        KIND_CG_SEL:  push_cmd(8'h40 | {2'b00, v[2:0], 3'b000}, 1'b1);
        default:      push_byte(1'b1, {3'b000, v[4:0]}, NIB_POST, 1'b1);
      endcase
    end
    return pending_xfers.size() - n0;
  endfunction

  task automatic send_req(input lcd_req_t rq, output int made);
    int cnt;
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= rq.kind;
    value_i    <= rq.value;
    col_i      <= rq.col;
    row_sel_i  <= rq.row_sel;
    do @(posedge clk_i); while (in_stall_o);
    cnt = predict_xfers(rq.kind, rq.value, rq.col, rq.row_sel);
    if (rq.typed) begin
      repeat (cnt) pending_xfers.delete(pending_xfers.size() - 1);
      if (rq.t_cnt != 0) push_byte(rq.t_rs, rq.t_byte, rq.t_post, 1'b1);
    end
    made = cnt;
  endtask

  task automatic drain_xfers();
    in_valid_i <= 1'b0;
    while (pending_xfers.size() != 0) @(posedge clk_i);
  endtask

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk_i) begin : rx_side
    lcd_xfer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_xfers.size() == 0) begin
        $display("%0t: unexpected nibble: rs=%0d nib=%h pre=%0d post=%0d last=%0d",
                 $time, rs_o, nibble_o, pre_wait_us_o, post_wait_us_o, last_o);
        mismatches++;
      end else begin
        want = pending_xfers.pop_front();
        if (want.rs !== rs_o || want.nibble !== nibble_o ||
            want.pre_wait !== pre_wait_us_o || want.post_wait !== post_wait_us_o ||
            want.last !== last_o) begin
          $display("%0t: mismatch: expected rs=%0d nib=%h pre=%0d post=%0d last=%0d",
                   $time, want.rs, want.nibble, want.pre_wait, want.post_wait, want.last);
          $display("%0t:           actual   rs=%0d nib=%h pre=%0d post=%0d last=%0d",
                   $time, rs_o, nibble_o, pre_wait_us_o, post_wait_us_o, last_o);
          mismatches++;
        end
      end
    end
    if (hold_go && !hold_done) begin
      hold_cnt  = 80;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_char_lcd_nibble_sequencer: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    lcd_req_t rq;
    int       made;
    int       useful;
    int       iter;
    int       p;

    // kind, value, col, row, typed, count, rs, byte, post
    dir_tbl[0]  = '{KIND_DATA,     8'h41, 8'h00, 8'h00, 1'b1, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[1]  = '{KIND_CLEAR,    8'h00, 8'h00, 8'h00, 1'b1, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[2]  = '{KIND_SHUTDOWN, 8'h00, 8'h00, 8'h00, 1'b1, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[3]  = '{KIND_CURSOR,   8'h00, 8'h7F, 8'h7F, 1'b1, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[4]  = '{KIND_INIT,     8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 13'd0};
    // repeated init is dropped
    dir_tbl[5]  = '{KIND_INIT,     8'hFF, 8'hFF, 8'hFF, 1'b1, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[6]  = '{KIND_DATA,     8'h00, 8'h00, 8'h00, 1'b1, 2'd2, 1'b1, 8'h00, 13'd40};
    dir_tbl[7]  = '{KIND_DATA,     8'hFF, 8'h00, 8'h00, 1'b1, 2'd2, 1'b1, 8'hFF, 13'd40};
    dir_tbl[8]  = '{KIND_COMMAND,  8'h01, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'h01, 13'd2040};
    dir_tbl[9]  = '{KIND_COMMAND,  8'h02, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'h02, 13'd2040};
    dir_tbl[10] = '{KIND_COMMAND,  8'h00, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'h00, 13'd80};
    dir_tbl[11] = '{KIND_COMMAND,  8'hFF, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'hFF, 13'd80};
    dir_tbl[12] = '{KIND_CLEAR,    8'h00, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'h01, 13'd2040};
    // cursor clamping at both ends of column and row
    dir_tbl[13] = '{KIND_CURSOR,   8'h00, 8'h80, 8'h80, 1'b1, 2'd2, 1'b0, 8'h80, 13'd80};
    dir_tbl[14] = '{KIND_CURSOR,   8'h00, 8'h7F, 8'h7F, 1'b1, 2'd2, 1'b0, 8'hE7, 13'd80};
    dir_tbl[15] = '{KIND_CURSOR,   8'h00, 8'h13, 8'h01, 1'b1, 2'd2, 1'b0, 8'hD3, 13'd80};
    dir_tbl[16] = '{KIND_CURSOR,   8'h00, 8'h14, 8'h04, 1'b1, 2'd2, 1'b0, 8'hE7, 13'd80};
    dir_tbl[17] = '{KIND_CURSOR,   8'h00, 8'h00, 8'h02, 1'b1, 2'd2, 1'b0, 8'h94, 13'd80};
    dir_tbl[18] = '{KIND_CURSOR,   8'h00, 8'h05, 8'h03, 1'b0, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[19] = '{KIND_CG_SEL,   8'hFF, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'h78, 13'd80};
    dir_tbl[20] = '{KIND_CG_SEL,   8'h00, 8'h00, 8'h00, 1'b1, 2'd2, 1'b0, 8'h40, 13'd80};
    dir_tbl[21] = '{KIND_CG_ROW,   8'hFF, 8'h00, 8'h00, 1'b1, 2'd2, 1'b1, 8'h1F, 13'd40};
    dir_tbl[22] = '{KIND_CG_ROW,   8'hA0, 8'h00, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[23] = '{KIND_SHUTDOWN, 8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[24] = '{KIND_DATA,     8'h5A, 8'h00, 8'h00, 1'b1, 2'd0, 1'b0, 8'h00, 13'd0};
    dir_tbl[25] = '{KIND_INIT,     8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 13'd0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 26; i++) send_req(dir_tbl[i], made);

    useful = 0;
    iter   = 0;
    while (useful < RAND_GOAL && iter < 600) begin
      p = $urandom_range(0, 99);
      if (!lcd_on) begin
        rq.kind = (p < 80) ? KIND_INIT : kind_e'($urandom_range(1, 7));
      end else if (p < 3)  rq.kind = KIND_INIT;
      else if (p < 8)      rq.kind = KIND_SHUTDOWN;
      else if (p < 14)     rq.kind = KIND_CLEAR;
      else if (p < 32)     rq.kind = KIND_COMMAND;
      else if (p < 55)     rq.kind = KIND_DATA;
      else if (p < 75)     rq.kind = KIND_CURSOR;
      else if (p < 87)     rq.kind = KIND_CG_SEL;
      else                 rq.kind = KIND_CG_ROW;
      rq.value = $urandom_range(0, 255);
      // slow commands deserve more than their fair share
      if (rq.kind == KIND_COMMAND && $urandom_range(0, 3) == 0)
        rq.value = $urandom_range(1, 2);
      rq.col     = $urandom_range(0, 1) ? 8'($urandom_range(0, COLUMNS - 1))
                                        : 8'($urandom_range(0, 255));
      rq.row_sel = $urandom_range(0, 1) ? 8'($urandom_range(0, ROWS - 1))
                                        : 8'($urandom_range(0, 255));
      rq.typed   = 1'b0;
      rq.t_cnt   = '0;
      rq.t_rs    = 1'b0;
      rq.t_byte  = '0;
      rq.t_post  = '0;

      if (useful == 30) hold_go <= 1'b1;
      if (useful == 60) drain_xfers();
      calm = (useful >= 62 && useful < 85);

      send_req(rq, made);
      if (made > 0) useful++;
      iter++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    drain_xfers();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_char_lcd_nibble_sequencer: PASS");
    end else begin
      $display("tb_char_lcd_nibble_sequencer: FAIL");
    end
    $finish;
  end

endmodule
